>>> rtl/core/blift_pkg.sv
// blift_pkg: shared types, codes and constants of the binary lifting core
// no dependencies

package blift_pkg;

	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 32;

	localparam int NODE_W  = 10;
	localparam int STEP_W  = 32;
	localparam int CNT_W   = 11;
	localparam int LVL_W   = 6;
	localparam int CFG_IW  = 2;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 16;

	localparam logic [STEP_W-1:0] MAX_STEPS_RST   = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0]  ENTRY_COUNT_RST = 11'd1024;

	localparam logic [CFG_IW-1:0] CFG_MAX_STEPS   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_ENTRY_COUNT = 2'd1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_COUNT     = 2'd2,
		ST_NOT_BUILT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_B_RD1,
		S_B_RD2,
		S_B_WR,
		S_Q_STEP,
		S_Q_WAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [STEP_W-1:0] max_steps;
		logic [CNT_W-1:0]  n;
		logic [LVL_W-1:0]  levels;
	} cfg_t;

	typedef struct packed {
		logic [NODE_W-1:0] end_node;
		status_t           status;
	} res_t;

	function automatic logic [LVL_W-1:0] bit_len(input logic [STEP_W-1:0] v);
		logic [LVL_W-1:0] k;
		k = '0;
		for (int j = 0; j < STEP_W; j++) begin
			if (v[j]) k = LVL_W'(j + 1);
		end
		return k;
	endfunction

endpackage

>>> rtl/core/blift_ram.sv
// blift_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module blift_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/blift_ctrl.sv
// blift_ctrl: sequencer driving the shared table lookup for load, build and query
// depends on blift_pkg and blift_ram

module blift_ctrl #(
	parameter int NODES  = blift_pkg::NODES_DEF,
	parameter int LEVELS = blift_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_accept,
	input  logic [1:0]                  in_op,
	input  logic [blift_pkg::NODE_W-1:0] in_node,
	input  logic [blift_pkg::NODE_W-1:0] in_value,
	input  logic [blift_pkg::STEP_W-1:0] in_count,
	input  blift_pkg::cfg_t             cfg,
	input  logic                        cfg_clr,
	output logic                        idle,
	output logic                        done,
	input  logic                        take,
	output blift_pkg::res_t             res
);

	localparam int NODE_AW = $clog2(NODES);
	localparam int LAW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DEPTH   = LEVELS << NODE_AW;
	localparam int ADDR_W  = $clog2(DEPTH);

	blift_pkg::state_t state_q, state_d;
	logic [1:0]                   op_q;
	logic [blift_pkg::NODE_W-1:0] node_q, value_q, at_q, at_d;
	logic [blift_pkg::STEP_W-1:0] count_q, count_d;
	logic [blift_pkg::LVL_W-1:0]  k_q, k_d, blevels_q, blevels_d;
	logic [NODE_AW-1:0]           i_q, i_d;
	logic                         built_q, built_d;
	blift_pkg::res_t              res_q, res_d;

	logic                         we;
	logic [ADDR_W-1:0]            waddr, raddr;
	logic [blift_pkg::NODE_W-1:0] wdata, rdata;
	logic                         node_ovr, value_ovr, count_ovr;
	logic [blift_pkg::LVL_W-1:0]  k_prev;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [blift_pkg::LVL_W-1:0] lvl,
			input logic [NODE_AW-1:0] nd);
		return ADDR_W'({lvl[LAW-1:0], nd});
	endfunction

	blift_ram #(
		.WIDTH(blift_pkg::NODE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign node_ovr  = {1'b0, node_q} >= cfg.n;
	assign value_ovr = {1'b0, value_q} >= cfg.n;
	assign count_ovr = (count_q > cfg.max_steps)
		|| ((blevels_q < blift_pkg::LVL_W'(blift_pkg::STEP_W)) && ((count_q >> blevels_q) != '0));
	assign k_prev = k_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= blift_pkg::S_IDLE;
			built_q   <= 1'b0;
			blevels_q <= '0;
		end else begin
			state_q   <= state_d;
			built_q   <= built_d;
			blevels_q <= blevels_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= in_op;
			node_q  <= in_node;
			value_q <= in_value;
		end
		count_q <= count_d;
		k_q     <= k_d;
		i_q     <= i_d;
		at_q    <= at_d;
		res_q   <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		built_d   = built_q;
		blevels_d = blevels_q;
		count_d   = count_q;
		k_d       = k_q;
		i_d       = i_q;
		at_d      = at_q;
		res_d     = res_q;
		we        = 1'b0;
		waddr     = addr_of(k_q, i_q);
		wdata     = rdata;
		raddr     = addr_of(k_q, NODE_AW'(at_q));
		idle      = 1'b0;
		done      = 1'b0;

		unique case (state_q)
			blift_pkg::S_IDLE: begin
				idle = 1'b1;
				if (in_accept) begin
					count_d = in_count;
					res_d   = '{end_node: '0, status: blift_pkg::ST_OK};
					state_d = blift_pkg::S_DECODE;
				end
			end
			blift_pkg::S_DECODE: begin
				state_d = blift_pkg::S_FIN;
				unique case (op_q)
					blift_pkg::OP_LOAD: begin
						if (node_ovr || value_ovr) begin
							res_d.status = blift_pkg::ST_RANGE;
						end else begin
							we      = 1'b1;
							waddr   = addr_of('0, NODE_AW'(node_q));
							wdata   = value_q;
							built_d = 1'b0;
						end
					end
					blift_pkg::OP_BUILD: begin
						if (cfg.levels <= blift_pkg::LVL_W'(1) || cfg.n == '0) begin
							built_d   = 1'b1;
							blevels_d = cfg.levels;
						end else begin
							k_d     = blift_pkg::LVL_W'(1);
							i_d     = '0;
							state_d = blift_pkg::S_B_RD1;
						end
					end
					blift_pkg::OP_QUERY: begin
						priority if (node_ovr) begin
							res_d.status = blift_pkg::ST_RANGE;
						end else if (count_ovr) begin
							res_d.status = blift_pkg::ST_COUNT;
						end else if (!built_q) begin
							res_d.status = blift_pkg::ST_NOT_BUILT;
						end else begin
							at_d    = node_q;
							k_d     = '0;
							state_d = blift_pkg::S_Q_STEP;
						end
					end
					default: ;
				endcase
			end
			blift_pkg::S_B_RD1: begin
				raddr   = addr_of(k_prev, i_q);
				state_d = blift_pkg::S_B_RD2;
			end
			blift_pkg::S_B_RD2: begin
				raddr   = addr_of(k_prev, NODE_AW'(rdata));
				state_d = blift_pkg::S_B_WR;
			end
			blift_pkg::S_B_WR: begin
				we    = 1'b1;
				waddr = addr_of(k_q, i_q);
				wdata = rdata;
				if (blift_pkg::CNT_W'(i_q) == cfg.n - 1'b1) begin
					i_d = '0;
					if (k_q == cfg.levels - 1'b1) begin
						built_d   = 1'b1;
						blevels_d = cfg.levels;
						state_d   = blift_pkg::S_FIN;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = blift_pkg::S_B_RD1;
					end
				end else begin
					i_d     = i_q + 1'b1;
					state_d = blift_pkg::S_B_RD1;
				end
			end
			blift_pkg::S_Q_STEP: begin
				if (count_q == '0) begin
					res_d.end_node = at_q;
					state_d        = blift_pkg::S_FIN;
				end else if (count_q[0]) begin
					raddr   = addr_of(k_q, NODE_AW'(at_q));
					state_d = blift_pkg::S_Q_WAIT;
				end else begin
					count_d = count_q >> 1;
					k_d     = k_q + 1'b1;
				end
			end
			blift_pkg::S_Q_WAIT: begin
				at_d    = rdata;
				count_d = count_q >> 1;
				k_d     = k_q + 1'b1;
				state_d = blift_pkg::S_Q_STEP;
			end
			blift_pkg::S_FIN: begin
				done = 1'b1;
				if (take) state_d = blift_pkg::S_IDLE;
			end
			default: state_d = blift_pkg::S_IDLE;
		endcase

		if (cfg_clr) built_d = 1'b0;
	end

	assign res = res_q;

endmodule

>>> rtl/core/binary_lifting_function_iterate_core.sv
// binary_lifting_function_iterate_core: top level, config registers and result register
// depends on blift_pkg and blift_ctrl
//
// channel   dir  tdata                                     tuser
// s_axis    in   [9:0] node_index [19:10] entry_value      [1:0] op
//                [51:20] step_count, rest zero
// m_axis    out  [9:0] end_node, rest zero                 [1:0] status
// cfg       in   cfg_we, cfg_index, cfg_data (no read-back)
//
// load, unused op and a query with an error status: decode, then straight to the result
// answered query: one step per bit of step_count up to its top set bit, one ram read per set bit
// build: each entry of levels 1 to levels - 1 takes two reads on the one ram read port, then a write
// the table ram is not cleared at reset; contents are undefined until loaded and built
// s_axis_tready is high only while the sequencer is idle
// a finished result waits in the output register while the next transaction is taken

module binary_lifting_function_iterate_core #(
	parameter int NODES  = blift_pkg::NODES_DEF,
	parameter int LEVELS = blift_pkg::LEVELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [blift_pkg::S_TDATA_W-1:0] s_axis_tdata,  // node_index, entry_value, step_count
	input  logic [1:0]                     s_axis_tuser,  // op
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [blift_pkg::M_TDATA_W-1:0] m_axis_tdata,  // end_node
	output logic [1:0]                     m_axis_tuser,  // status
	input  logic                           cfg_we,
	input  logic [blift_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [blift_pkg::STEP_W-1:0]   cfg_data
);

	blift_pkg::cfg_t  cfg_q;
	blift_pkg::res_t  res, out_q;
	logic             out_valid_q;
	logic             idle, done, take, in_accept, cfg_clr;

	function automatic logic [blift_pkg::LVL_W-1:0] levels_of(
			input logic [blift_pkg::STEP_W-1:0] v);
		logic [blift_pkg::LVL_W-1:0] bl;
		bl = blift_pkg::bit_len(v);
		return (32'(bl) < LEVELS) ? bl : blift_pkg::LVL_W'(LEVELS);
	endfunction

	function automatic logic [blift_pkg::CNT_W-1:0] nodes_of(
			input logic [blift_pkg::CNT_W-1:0] c);
		return (32'(c) < NODES) ? c : blift_pkg::CNT_W'(NODES);
	endfunction

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = idle;
	assign take          = done && (!out_valid_q || m_axis_tready);
	assign cfg_clr       = cfg_we && (cfg_index == blift_pkg::CFG_MAX_STEPS
		|| cfg_index == blift_pkg::CFG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_steps <= blift_pkg::MAX_STEPS_RST;
			cfg_q.levels    <= levels_of(blift_pkg::MAX_STEPS_RST);
			cfg_q.n         <= nodes_of(blift_pkg::ENTRY_COUNT_RST);
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == blift_pkg::CFG_MAX_STEPS) begin
				cfg_q.max_steps <= cfg_data;
				cfg_q.levels    <= levels_of(cfg_data);
			end
			if (cfg_we && cfg_index == blift_pkg::CFG_ENTRY_COUNT) begin
				cfg_q.n <= nodes_of(cfg_data[blift_pkg::CNT_W-1:0]);
			end
			if (take) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end

	blift_ctrl #(
		.NODES (NODES),
		.LEVELS(LEVELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_accept(in_accept),
		.in_op    (s_axis_tuser),
		.in_node  (s_axis_tdata[9:0]),
		.in_value (s_axis_tdata[19:10]),
		.in_count (s_axis_tdata[51:20]),
		.cfg      (cfg_q),
		.cfg_clr  (cfg_clr),
		.idle     (idle),
		.done     (done),
		.take     (take),
		.res      (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = blift_pkg::M_TDATA_W'(out_q.end_node);
	assign m_axis_tuser  = out_q.status;

endmodule

>>> rtl/core/blift_chk.sv
// blift_chk: port-level checker for the binary lifting core, bound to the top level
// depends on blift_pkg and binary_lifting_function_iterate_core

module blift_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [blift_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic [1:0]                     m_axis_tuser
);

	// one transaction in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// no result can appear the cycle right after a transaction is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");

	// error results carry a zero node
	a_error_zero_node: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != blift_pkg::ST_OK |-> m_axis_tdata == '0)
		else $error("error result with nonzero node");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind binary_lifting_function_iterate_core blift_chk u_blift_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

>>> test/tb_binary_lifting_function_iterate_core.sv
// tb_binary_lifting_function_iterate_core: self-checking bench for the binary lifting core
// stream driver and monitor around the core, with its own successor-table predictor
// depends on blift_pkg and binary_lifting_function_iterate_core
`timescale 1ns / 100ps

module tb_binary_lifting_function_iterate_core;

	localparam int NODE_CNT = blift_pkg::NODES_DEF;
	localparam int LVL_CNT = blift_pkg::LEVELS_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_TARGET = 840;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [blift_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]                   op;
		logic [blift_pkg::NODE_W-1:0] node;
		logic [blift_pkg::NODE_W-1:0] value;
		logic [blift_pkg::STEP_W-1:0] count;
	} lift_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [blift_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [blift_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [blift_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [blift_pkg::STEP_W-1:0] cfg_data = '0;

	// predictor state
	logic [blift_pkg::NODE_W-1:0] jump_tbl [0:LVL_CNT-1][0:NODE_CNT-1];
	logic tbl_ready = 1'b0;
	int unsigned ready_levels = 0;
	logic [blift_pkg::STEP_W-1:0] limit_steps = blift_pkg::MAX_STEPS_RST;
	int unsigned active_nodes = NODE_CNT;

	lift_req_t pending_req [$];
	lift_req_t cur_req;
	blift_pkg::res_t expected_res [$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int unsigned random_items = 0;
	int unsigned phase_cnt = 0;
	int unsigned load_cnt = 0, build_cnt = 0, query_cnt = 0, other_cnt = 0;
	int unsigned checked_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	binary_lifting_function_iterate_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic blift_pkg::res_t lift_predict(input lift_req_t req);
		blift_pkg::res_t r;
		int unsigned lv;
		logic [blift_pkg::STEP_W-1:0] v;
		logic [blift_pkg::NODE_W-1:0] at;
		logic [63:0] wide;
		r.end_node = '0;
		r.status = blift_pkg::ST_OK;
		unique case (req.op)
		blift_pkg::OP_LOAD: begin
			if (req.node >= active_nodes || req.value >= active_nodes) begin
				r.status = blift_pkg::ST_RANGE;
			end else begin
				jump_tbl[0][req.node] = req.value;
				tbl_ready = 1'b0;
			end
		end
		blift_pkg::OP_BUILD: begin
			lv = 0;
			v = limit_steps;
			while (v != 0) begin
				lv++;
				v >>= 1;
			end
			if (lv > LVL_CNT) lv = LVL_CNT;
			// level k is level k-1 applied twice
			for (int k = 1; k < lv; k++) begin
				for (int i = 0; i < active_nodes; i++) begin
					jump_tbl[k][i] = jump_tbl[k-1][jump_tbl[k-1][i]];
				end
			end
			ready_levels = lv;
			tbl_ready = 1'b1;
		end
		blift_pkg::OP_QUERY: begin
			wide = {32'b0, req.count};
			if (req.node >= active_nodes) begin
				r.status = blift_pkg::ST_RANGE;
			end else if (req.count > limit_steps || (wide >> ready_levels) != 0) begin
				r.status = blift_pkg::ST_COUNT;
			end else if (!tbl_ready) begin
				r.status = blift_pkg::ST_NOT_BUILT;
			end else begin
				at = req.node;
				for (int k = 0; k < blift_pkg::STEP_W; k++) begin
					if (req.count[k]) at = jump_tbl[k][at];
				end
				r.end_node = at;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				expected_res.push_back(lift_predict(cur_req));
				unique case (cur_req.op)
				blift_pkg::OP_LOAD: load_cnt++;
				blift_pkg::OP_BUILD: build_cnt++;
				blift_pkg::OP_QUERY: query_cnt++;
				default: other_cnt++;
				endcase
			end
			if (pending_req.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				cur_req = pending_req.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'b0, cur_req.count, cur_req.value, cur_req.node};
				s_axis_tuser <= cur_req.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		blift_pkg::res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				checked_cnt++;
				if (expected_res.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result transaction: node %0d status %0d",
							m_axis_tdata, m_axis_tuser);
				end else begin
					want = expected_res.pop_front();
					if (m_axis_tdata !== blift_pkg::M_TDATA_W'(want.end_node) ||
							m_axis_tuser !== want.status) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: expected node %0d status %0d, got node %0d status %0d",
								want.end_node, want.status, m_axis_tdata, m_axis_tuser);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("status: fail");
		$finish;
	end

	task automatic push_item(input logic [1:0] op, input int unsigned node,
			input int unsigned value, input logic [blift_pkg::STEP_W-1:0] count);
		lift_req_t req;
		req.op = op;
		req.node = blift_pkg::NODE_W'(node);
		req.value = blift_pkg::NODE_W'(value);
		req.count = count;
		pending_req.push_back(req);
	endtask

	task automatic push_random(input logic [1:0] op, input int unsigned node,
			input int unsigned value, input logic [blift_pkg::STEP_W-1:0] count);
		push_item(op, node, value, count);
		if (op != OP_UNUSED) random_items++;
	endtask

	task automatic drain_results();
		do @(posedge clk);
		while (pending_req.size() != 0 || s_axis_tvalid || expected_res.size() != 0);
	endtask

	task automatic write_reg(input logic [blift_pkg::CFG_IW-1:0] idx,
			input logic [blift_pkg::STEP_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		unique case (idx)
		blift_pkg::CFG_MAX_STEPS: begin
			limit_steps = val;
			tbl_ready = 1'b0;
		end
		blift_pkg::CFG_ENTRY_COUNT: begin
			active_nodes = (val[blift_pkg::CNT_W-1:0] < NODE_CNT) ?
				val[blift_pkg::CNT_W-1:0] : NODE_CNT;
			tbl_ready = 1'b0;
		end
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [blift_pkg::STEP_W-1:0] rand_count(
			input logic [blift_pkg::STEP_W-1:0] ms);
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return (ms == '1) ? $urandom : $urandom_range(ms, 0);
		else if (r < 70)
			return $urandom_range((ms < 40) ? ms : 40, 0);
		else if (r < 78)
			return ms;
		else if (r < 83)
			return '0;
		else if (r < 93 && ms != '1)
			return $urandom_range(32'hFFFF_FFFF, ms + 1);
		return $urandom;
	endfunction

	function automatic logic [blift_pkg::STEP_W-1:0] rand_limit();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '1;
		else if (r < 30)
			return (32'd1 << $urandom_range(31)) - 1;
		else if (r < 45)
			return 32'd1 << $urandom_range(31);
		return $urandom >> $urandom_range(31);
	endfunction

	// write the config, up to two queries, then reload the whole map, build, and a random mix over it
	task automatic run_phase(input logic [blift_pkg::STEP_W-1:0] ms, input int unsigned n,
			input int unsigned extra);
		int r;
		drain_results();
		phase_cnt++;
		if ($urandom_range(1)) begin
			write_reg(blift_pkg::CFG_ENTRY_COUNT, n);
			write_reg(blift_pkg::CFG_MAX_STEPS, ms);
		end else begin
			write_reg(blift_pkg::CFG_MAX_STEPS, ms);
			write_reg(blift_pkg::CFG_ENTRY_COUNT, n);
		end
		repeat ($urandom_range(2))
			push_random(blift_pkg::OP_QUERY, $urandom_range(n - 1), $urandom, rand_count(ms));
		for (int i = 0; i < n; i++)
			push_random(blift_pkg::OP_LOAD, i, $urandom_range(n - 1), $urandom);
		push_random(blift_pkg::OP_BUILD, $urandom, $urandom, $urandom);
		repeat (extra) begin
			r = $urandom_range(99);
			if (r < 70) begin
				push_random(blift_pkg::OP_QUERY, $urandom_range(n - 1), $urandom,
					rand_count(ms));
			end else if (r < 78) begin
				push_random(blift_pkg::OP_LOAD, $urandom_range(n - 1),
					$urandom_range(n - 1), $urandom);
			end else if (r < 84 && n < NODE_CNT) begin
				if ($urandom_range(1))
					push_random(blift_pkg::OP_LOAD, $urandom_range(NODE_CNT - 1, n),
						$urandom, $urandom);
				else
					push_random(blift_pkg::OP_LOAD, $urandom_range(n - 1),
						$urandom_range(NODE_CNT - 1, n), $urandom);
			end else if (r < 90 && n <= 64) begin
				push_random(blift_pkg::OP_BUILD, $urandom, $urandom, $urandom);
			end else if (r < 94) begin
				push_random(OP_UNUSED, $urandom, $urandom, $urandom);
			end else if (n < NODE_CNT) begin
				push_random(blift_pkg::OP_QUERY, $urandom_range(NODE_CNT - 1, n), $urandom,
					rand_count(ms));
			end else begin
				push_random(blift_pkg::OP_QUERY, $urandom_range(n - 1), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		int unsigned p;
		int unsigned n;
		int unsigned leftover;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 29;
		snk_idle_pct = 67;

		// reset configuration, nothing loaded: not built, then too many levels
		push_item(blift_pkg::OP_QUERY, NODE_CNT - 1, 0, 32'd0);
		push_item(blift_pkg::OP_QUERY, 0, NODE_CNT - 1, 32'd1);
		push_item(OP_UNUSED, NODE_CNT - 1, NODE_CNT - 1, '1);
		drain_results();
		write_reg(blift_pkg::CFG_ENTRY_COUNT, 8);
		write_reg(blift_pkg::CFG_MAX_STEPS, 32'd1000);
		// loads out of range keep nothing
		push_item(blift_pkg::OP_LOAD, 8, 0, 32'd0);
		push_item(blift_pkg::OP_LOAD, 0, 8, 32'd0);
		push_item(blift_pkg::OP_LOAD, NODE_CNT - 1, NODE_CNT - 1, '1);
		for (int i = 0; i < 8; i++)
			push_item(blift_pkg::OP_LOAD, i, (i * 3 + 1) % 8, $urandom);
		push_item(blift_pkg::OP_BUILD, 0, 0, 32'd0);
		push_item(blift_pkg::OP_QUERY, 8, 0, 32'd1);
		push_item(blift_pkg::OP_QUERY, 3, 0, 32'd0);
		push_item(blift_pkg::OP_QUERY, 5, 0, 32'd1000);
		push_item(blift_pkg::OP_QUERY, 2, 0, 32'd1001);
		push_item(blift_pkg::OP_QUERY, 7, 0, '1);
		// a load drops the built table
		push_item(blift_pkg::OP_LOAD, 4, 4, 32'd0);
		push_item(blift_pkg::OP_QUERY, 4, 0, 32'd5);
		push_item(blift_pkg::OP_BUILD, 0, 0, 32'd0);
		drain_results();
		// write to an unmapped register leaves the table usable
		write_reg(CFG_UNUSED, '1);
		push_item(blift_pkg::OP_QUERY, 6, 0, 32'd777);

		p = 0;
		while (random_items < RANDOM_TARGET) begin
			if (random_items < RANDOM_TARGET / 3) begin
				src_idle_pct = 29;
				snk_idle_pct = 67;
			end else if (random_items < 2 * RANDOM_TARGET / 3) begin
				src_idle_pct = 67;
				snk_idle_pct = 29;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			n = ($urandom_range(99) < 80) ? $urandom_range(40, 1) : $urandom_range(300, 100);
			case (p)
			0: run_phase('0, $urandom_range(16, 2), 40);
			1: run_phase(32'd1, 1, 40);
			2: run_phase('1, 2, 60);
			default: run_phase(rand_limit(), n, 60);
			endcase
			p++;
		end

		drain_results();
		repeat (100) @(posedge clk);
		leftover = expected_res.size();
		$display("covered %0d loads, %0d builds, %0d queries, %0d unused-op transactions",
			load_cnt, build_cnt, query_cnt, other_cnt);
		$display("over %0d settings: %0d results checked, %0d mismatches",
			phase_cnt, checked_cnt, mismatch_cnt + leftover);
		if (mismatch_cnt == 0 && leftover == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
